@@ rtl/clipped_line_rasterizer_unit_macros.svh @@
// Assertion macros shared by the clipped line rasterizer RTL.
// Depends on nothing; included by the top level only.
`ifndef CLIPPED_LINE_RASTERIZER_UNIT_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CLR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clipped_line_rasterizer_unit: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clipped_line_rasterizer_unit: next-cycle check failed");

`endif

@@ rtl/clr_pkg.sv @@
// Package for the clipped line rasterizer: field widths, register indexes,
// command and pixel records, and the side clamp. No dependencies.
package clr_pkg;

   // Field widths fixed by the command and result formats.
   localparam int COORD_W     = 6;
   localparam int SIDE_W      = 7;
   localparam int ADDR_W      = 12;
   localparam int COLOR_W     = 32;
   localparam int ERR_W       = COORD_W + 3;
   localparam int MAX_SIDE    = 64;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   // Command queue depth between front and walker.
   localparam int QUEUE_DEPTH = 2;

   // Control register port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_SURFACE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SURFACE_HEIGHT = 1'd1;
   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

   // One classified line command.
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] delta_x;
      logic [COORD_W-1:0] delta_y;
      logic               step_x_neg;
      logic               step_y_neg;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   // One plotted point.
   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               inside_res;
      logic               last;
   } pixel_type;

   // Walker status seen by the top level.
   typedef struct packed {
      logic busy;
   } walk_status_type;

   // Sides above the surface maximum behave as the maximum.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
      clamp_side = (side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side;
   endfunction

endpackage

@@ rtl/clr_front.sv @@
// Command front end: unpacks a line command and works out its deltas and
// step directions. Depends on clr_pkg.
module clr_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [clr_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            push_valid,
   input  logic                            push_ready,
   output clr_pkg::cmd_type                push_cmd
);

   logic [clr_pkg::COORD_W-1:0] sx;
   logic [clr_pkg::COORD_W-1:0] sy;
   logic [clr_pkg::COORD_W-1:0] ex;
   logic [clr_pkg::COORD_W-1:0] ey;

   // Unpack the command fields from the lowest bit up.
   assign sx = req_tdata[5:0];
   assign sy = req_tdata[11:6];
   assign ex = req_tdata[17:12];
   assign ey = req_tdata[23:18];

   // The command enters the queue in the cycle of its transfer.
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   // Absolute deltas and step directions of the line.
   always_comb begin
      push_cmd            = '0;
      push_cmd.start_x    = sx;
      push_cmd.start_y    = sy;
      push_cmd.end_x      = ex;
      push_cmd.end_y      = ey;
      push_cmd.delta_x    = (ex > sx) ? ex - sx : sx - ex;
      push_cmd.delta_y    = (ey > sy) ? ey - sy : sy - ey;
      push_cmd.step_x_neg = !(sx < ex);
      push_cmd.step_y_neg = !(sy < ey);
      push_cmd.color      = req_tdata[55:24];
   end

endmodule

@@ rtl/clr_cmd_queue.sv @@
// Short first-in first-out queue of classified line commands between the
// front end and the walker. Depends on clr_pkg.
module clr_cmd_queue #(
   parameter int DEPTH = clr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  clr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output clr_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   clr_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push_fire;
   logic pop_fire;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry payload only.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/clr_walker.sv @@
// Line walker: steps the Bresenham error term one point per cycle unless
// stalled; registers each point, clip flag and address. Depends on clr_pkg.
module clr_walker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [clr_pkg::SIDE_W-1:0]   width_clamped,
   input  logic [clr_pkg::SIDE_W-1:0]   height_clamped,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  clr_pkg::cmd_type             pop_cmd,
   output logic                         out_valid,
   input  logic                         out_ready,
   output clr_pkg::pixel_type           out_pixel,
   output clr_pkg::walk_status_type     status
);

   localparam int COORD_W = clr_pkg::COORD_W;
   localparam int ERR_W   = clr_pkg::ERR_W;
   localparam int ADDR_W  = clr_pkg::ADDR_W;

   logic                        busy_ff, busy_in;
   logic [COORD_W-1:0]          cx_ff, cx_in;
   logic [COORD_W-1:0]          cy_ff, cy_in;
   logic signed [ERR_W-1:0]     err_ff, err_in;
   clr_pkg::cmd_type            cmd_ff, cmd_in;
   logic                        out_valid_ff, out_valid_in;
   clr_pkg::pixel_type          out_pixel_ff, out_pixel_in;

   logic                        advance;
   logic                        done;
   logic                        load;
   logic                        in_bounds;
   logic signed [ERR_W:0]       e2;
   logic signed [ERR_W:0]       dx_s;
   logic signed [ERR_W:0]       dy_s;
   logic                        step_x;
   logic                        step_y;
   logic [ADDR_W:0]             addr_full;

   // A point moves out when the output register is free or being drained.
   assign advance   = busy_ff && (!out_valid_ff || out_ready);
   assign done      = (cx_ff == cmd_ff.end_x) && (cy_ff == cmd_ff.end_y);
   assign pop_ready = !busy_ff || (advance && done);
   assign load      = pop_valid && pop_ready;

   // Error-term step decisions.
   assign e2     = {err_ff, 1'b0};
   assign dx_s   = (ERR_W + 1)'(cmd_ff.delta_x);
   assign dy_s   = (ERR_W + 1)'(cmd_ff.delta_y);
   assign step_x = (e2 > -dy_s);
   assign step_y = (e2 < dx_s);

   // Clip test and linear address of the current point.
   assign in_bounds = ({1'b0, cx_ff} < width_clamped) && ({1'b0, cy_ff} < height_clamped);
   assign addr_full = (ADDR_W + 1)'(cy_ff * width_clamped) + (ADDR_W + 1)'(cx_ff);

   // Walker state: load a new line or take one step.
   always_comb begin
      busy_in = busy_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      err_in  = err_ff;
      cmd_in  = cmd_ff;
      if (load) begin
         busy_in = 1'b1;
         cmd_in  = pop_cmd;
         cx_in   = pop_cmd.start_x;
         cy_in   = pop_cmd.start_y;
         err_in  = ERR_W'($signed({1'b0, pop_cmd.delta_x}))
                 - ERR_W'($signed({1'b0, pop_cmd.delta_y}));
      end else if (advance && done) begin
         busy_in = 1'b0;
      end else if (advance) begin
         if (step_x && step_y) begin
            err_in = err_ff - ERR_W'(dy_s) + ERR_W'(dx_s);
         end else if (step_x) begin
            err_in = err_ff - ERR_W'(dy_s);
         end else if (step_y) begin
            err_in = err_ff + ERR_W'(dx_s);
         end
         if (step_x) begin
            cx_in = cmd_ff.step_x_neg ? cx_ff - 1'b1 : cx_ff + 1'b1;
         end
         if (step_y) begin
            cy_in = cmd_ff.step_y_neg ? cy_ff - 1'b1 : cy_ff + 1'b1;
         end
      end
   end

   // Output register: loaded on a step, emptied by a transfer.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (advance) begin
         out_valid_in               = 1'b1;
         out_pixel_in.pixel_x       = cx_ff;
         out_pixel_in.pixel_y       = cy_ff;
         out_pixel_in.pixel_address = in_bounds ? addr_full[ADDR_W-1:0] : '0;
         out_pixel_in.pixel_color   = cmd_ff.color;
         out_pixel_in.inside_res    = in_bounds;
         out_pixel_in.last          = done;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      err_ff       <= err_in;
      cmd_ff       <= cmd_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_pixel   = out_pixel_ff;
   assign status.busy = busy_ff;

endmodule

@@ rtl/clipped_line_rasterizer_unit.sv @@
// Top level of the clipped line rasterizer: surface registers, front end,
// command queue and line walker. Depends on clr_pkg and the macros header.
//
// Each accepted line command yields one result per point of its Bresenham
// line, start and end included: max(|end_x - start_x|, |end_y - start_y|) + 1
// results, 1 to 64. The walker produces one point per cycle when the result
// side keeps taking them; the next queued command is loaded in the same
// cycle as the last point of the current line moves to the output register.
// Up to QUEUE_DEPTH commands wait in the queue; until it is full, the command
// side keeps taking transfers while a line is drawn. Points outside the surface
// width or height are still delivered with inside_res low and address zero.
// Width and height above 64 act as 64; write them only while the block is idle.
`include "clipped_line_rasterizer_unit_macros.svh"

module clipped_line_rasterizer_unit #(
   parameter int QUEUE_DEPTH = clr_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel. tdata: start_x[5:0], start_y[11:6], end_x[17:12],
   // end_y[23:18], draw_color[55:24].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [clr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Point channel. tdata: pixel_x[5:0], pixel_y[11:6],
   // pixel_address[23:12], pixel_color[55:24].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [clr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,   // inside_res[0]
   output logic                            rsp_tlast,
   // Register write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [clr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clr_pkg::SIDE_W-1:0]      csr_data
);

   logic [clr_pkg::SIDE_W-1:0] width_ff, width_in;
   logic [clr_pkg::SIDE_W-1:0] height_ff, height_in;
   logic [clr_pkg::SIDE_W-1:0] width_clamped;
   logic [clr_pkg::SIDE_W-1:0] height_clamped;

   logic                       push_valid;
   logic                       push_ready;
   clr_pkg::cmd_type           push_cmd;
   logic                       pop_valid;
   logic                       pop_ready;
   clr_pkg::cmd_type           pop_cmd;
   clr_pkg::pixel_type         pixel;
   clr_pkg::walk_status_type   walk_status;

   // Surface registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            clr_pkg::REG_SURFACE_WIDTH:  width_in  = csr_data;
            clr_pkg::REG_SURFACE_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clr_pkg::SIDE_RESET;
         height_ff <= clr_pkg::SIDE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width_clamped  = clr_pkg::clamp_side(width_ff);
   assign height_clamped = clr_pkg::clamp_side(height_ff);

   // Front end, queue and walker.
   clr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   clr_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   clr_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .width_clamped  (width_clamped),
      .height_clamped (height_clamped),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_cmd        (pop_cmd),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_pixel      (pixel),
      .status         (walk_status)
   );

   // Pack the point onto the result channel.
   assign rsp_tdata = {pixel.pixel_color, pixel.pixel_address, pixel.pixel_y, pixel.pixel_x};
   assign rsp_tuser = pixel.inside_res;
   assign rsp_tlast = pixel.last;

   // A clipped point carries a zero address.
   `CLR_ASSERT_IMPLY(a_clipped_addr_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[23:12] == '0)
   // An inside point lies within the clamped surface.
   `CLR_ASSERT_IMPLY(a_inside_in_bounds, clock, reset, rsp_tvalid && rsp_tuser, ({1'b0, rsp_tdata[5:0]} < width_clamped) && ({1'b0, rsp_tdata[11:6]} < height_clamped))
   // An inside point's address matches its row and column.
   `CLR_ASSERT_IMPLY(a_inside_addr, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[23:12] == clr_pkg::ADDR_W'(rsp_tdata[11:6] * width_clamped + clr_pkg::ADDR_W'(rsp_tdata[5:0])))
   // An accepted command is held either in the queue or by the walker.
   `CLR_ASSERT_NEXT(a_cmd_held, clock, reset, req_tvalid && req_tready, pop_valid || walk_status.busy)

endmodule
